>>> sv/dq_pkg.sv
// Package for the row-wise 8-bit dequantizer: word types, register codes and
// fp32 / fp16 / bf16 helper functions shared by the lanes and the top level.
// No dependencies.
package dq_pkg;

	localparam int LANES = 4;
	localparam int OUT_LANES = 4;
	localparam int CAP = (LANES < OUT_LANES) ? LANES : OUT_LANES;
	localparam logic [2:0] CAP_CNT = 3'(CAP);
	localparam int LANE_DEPTH = 7;

	localparam logic [1:0] FMT_FP32 = 2'd0;
	localparam logic [1:0] FMT_FP16 = 2'd1;

	localparam logic REG_OUT_FORMAT = 1'b0;
	localparam logic REG_SB_FLOAT = 1'b1;

	localparam logic [31:0] QNAN32 = 32'h7FC00000;
	localparam logic [15:0] QNAN16 = 16'h7E00;

	typedef struct packed {
		logic [7:0]  q_byte0;
		logic [7:0]  q_byte1;
		logic [7:0]  q_byte2;
		logic [7:0]  q_byte3;
		logic [2:0]  lanes_valid;
		logic [31:0] scale_bits;
		logic [31:0] bias_bits;
	} in_word_t;

	typedef struct packed {
		logic [31:0] out_lane0;
		logic [31:0] out_lane1;
		logic [31:0] out_lane2;
		logic [31:0] out_lane3;
		logic [2:0]  out_count;
	} out_word_t;

	// value = x * 2^(ee-150-rs) before rounding; ee is the biased result exponent
	typedef struct packed {
		logic              sign;
		logic              zero;
		logic              nan;
		logic              inf;
		logic [31:0]       x;
		logic [9:0]        ee;
		logic signed [6:0] rs;
	} rnd_t;

	function automatic logic [4:0] msb_pos(input logic [31:0] x);
		logic [4:0] p;
		p = '0;
		for (int i = 0; i < 32; i++) begin
			if (x[i]) begin
				p = 5'(i);
			end
		end
		return p;
	endfunction

	function automatic logic [31:0] half_to_single(input logic [15:0] h);
		logic [4:0]  e;
		logic [9:0]  m;
		logic [9:0]  mn;
		logic [3:0]  p;
		logic [31:0] r;
		e = h[14:10];
		m = h[9:0];
		p = '0;
		for (int i = 0; i < 10; i++) begin
			if (m[i]) begin
				p = 4'(i);
			end
		end
		mn = m << (4'd10 - p);
		if (e == 5'h1F) begin
			r = {h[15], 8'hFF, m, 13'd0};
		end else if (e == 5'd0) begin
			if (m == 10'd0) begin
				r = {h[15], 31'd0};
			end else begin
				r = {h[15], 8'(8'd103 + 8'(p)), mn, 13'd0};
			end
		end else begin
			r = {h[15], 8'(8'(e) + 8'd112), m, 13'd0};
		end
		return r;
	endfunction

	function automatic rnd_t norm(input logic sg, input logic z, input logic nan,
			input logic inf, input logic [31:0] x, input logic signed [9:0] k);
		rnd_t r;
		int p;
		int er;
		int ee;
		p = int'(msb_pos(x));
		er = p + int'(k) + 127;
		ee = (er < 1) ? 1 : er;
		r.sign = sg;
		r.zero = z;
		r.nan = nan;
		r.inf = inf;
		r.x = x;
		r.ee = 10'(ee);
		r.rs = 7'(ee - 150 - int'(k));
		return r;
	endfunction

	function automatic logic [31:0] round_pack(input rnd_t r);
		logic [31:0] rv;
		logic [31:0] msk;
		logic        g;
		logic        st;
		int          sh;
		int          pk;
		logic [31:0] res;
		sh = int'(r.rs);
		if (sh <= 0) begin
			rv = r.x << (-sh);
			g = 1'b0;
			st = 1'b0;
		end else begin
			rv = r.x >> sh;
			g = r.x[sh-1];
			msk = (32'd1 << (sh - 1)) - 32'd1;
			st = |(r.x & msk);
		end
		rv = rv + 32'(g & (st | rv[0]));
		pk = ((int'(r.ee) - 1) << 23) + int'(rv);
		if (r.nan) begin
			res = QNAN32;
		end else if (r.inf) begin
			res = {r.sign, 31'h7F800000};
		end else if (r.zero) begin
			res = {r.sign, 31'd0};
		end else if (r.ee > 10'd254 || pk >= 32'h7F800000) begin
			res = {r.sign, 31'h7F800000};
		end else begin
			res = {r.sign, 31'(pk)};
		end
		return res;
	endfunction

	function automatic logic [15:0] single_to_half(input logic [31:0] v);
		logic [7:0]  e;
		logic [22:0] m;
		logic [23:0] mm;
		logic [15:0] r;
		logic [23:0] rem;
		logic [23:0] half;
		logic [7:0]  sh;
		logic [15:0] res;
		e = v[30:23];
		m = v[22:0];
		mm = {1'b1, m};
		sh = 8'd126 - e;
		r = '0;
		if (e == 8'hFF) begin
			res = (m != 23'd0) ? QNAN16 : {v[31], 15'h7C00};
		end else if (e >= 8'd143) begin
			res = {v[31], 15'h7C00};
		end else if (e >= 8'd113) begin
			r = {1'b0, 5'(e - 8'd112), m[22:13]};
			if (m[12:0] > 13'h1000 || (m[12:0] == 13'h1000 && r[0])) begin
				r = r + 16'd1;
			end
			res = {v[31], 15'd0} | r;
		end else if (e == 8'd0 || sh >= 8'd25) begin
			res = {v[31], 15'd0};
		end else begin
			r = 16'(mm >> sh);
			rem = mm & ((24'd1 << sh) - 24'd1);
			half = 24'd1 << (sh - 8'd1);
			if (rem > half || (rem == half && r[0])) begin
				r = r + 16'd1;
			end
			res = {v[31], 15'd0} | r;
		end
		return res;
	endfunction

	function automatic logic [15:0] single_to_bf16(input logic [31:0] v);
		logic [32:0] r;
		r = {1'b0, v} + 33'h7FFF + 33'(v[16]);
		return r[31:16];
	endfunction

endpackage

>>> sv/dq_lane.sv
// One dequantizer lane: q * scale (rounded fp32), + bias (rounded fp32), then
// narrowing to the selected format. Seven register stages. Uses dq_pkg.
module dq_lane (
	input  logic        clk,
	input  logic [7:0]  q,
	input  logic [31:0] scale,
	input  logic [31:0] bias,
	input  logic [1:0]  fmt,
	output logic [31:0] res
);
	import dq_pkg::*;

	logic [31:0]       p_s1;
	logic signed [9:0] k_s1;
	logic              sg_s1, z_s1, nan_s1, inf_s1;
	logic [31:0]       bias_s1;
	rnd_t              m_s2;
	logic [31:0]       bias_s2;
	logic [31:0]       prod_s3;
	logic [31:0]       bias_s3;
	logic [31:0]       x_s4;
	logic signed [9:0] k_s4;
	logic              sg_s4, z_s4, nan_s4, inf_s4;
	rnd_t              a_s5;
	logic [31:0]       sum_s6;
	logic [31:0]       res_s7;

	logic [7:0]  se;
	logic [23:0] sm;
	logic        s_special;

	assign se = scale[30:23];
	assign sm = {se != 8'd0, scale[22:0]};
	assign s_special = (se == 8'hFF);

	always_ff @(posedge clk) begin
		p_s1    <= 32'(q) * 32'(sm);
		k_s1    <= 10'(((se == 8'd0) ? 10'd1 : {2'b0, se})) - 10'sd150;
		sg_s1   <= scale[31];
		z_s1    <= (q == 8'd0) || (sm == 24'd0);
		nan_s1  <= s_special && (scale[22:0] != 23'd0 || q == 8'd0);
		inf_s1  <= s_special && scale[22:0] == 23'd0 && q != 8'd0;
		bias_s1 <= bias;
	end

	always_ff @(posedge clk) begin
		m_s2    <= norm(sg_s1, z_s1, nan_s1, inf_s1, p_s1, k_s1);
		bias_s2 <= bias_s1;
		prod_s3 <= round_pack(m_s2);
		bias_s3 <= bias_s2;
	end

	// alignment add
	logic [31:0] big, sml;
	logic        a_nan, b_nan, a_inf, b_inf;
	logic [7:0]  eg, es, d;
	logic [31:0] gs, ss0, ssh, sum;
	logic        stk;

	always_comb begin
		a_nan = prod_s3[30:23] == 8'hFF && prod_s3[22:0] != 23'd0;
		b_nan = bias_s3[30:23] == 8'hFF && bias_s3[22:0] != 23'd0;
		a_inf = prod_s3[30:23] == 8'hFF && prod_s3[22:0] == 23'd0;
		b_inf = bias_s3[30:23] == 8'hFF && bias_s3[22:0] == 23'd0;
		if (prod_s3[30:0] >= bias_s3[30:0]) begin
			big = prod_s3;
			sml = bias_s3;
		end else begin
			big = bias_s3;
			sml = prod_s3;
		end
		eg = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
		es = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
		d = eg - es;
		gs = {5'd0, big[30:23] != 8'd0, big[22:0], 3'd0};
		ss0 = {5'd0, sml[30:23] != 8'd0, sml[22:0], 3'd0};
		if (d >= 8'd27) begin
			ssh = '0;
			stk = |ss0;
		end else begin
			ssh = ss0 >> d;
			stk = |(ss0 & ((32'd1 << d) - 32'd1));
		end
		ssh = ssh | 32'(stk);
		sum = (prod_s3[31] == bias_s3[31]) ? gs + ssh : gs - ssh;
	end

	always_ff @(posedge clk) begin
		x_s4   <= sum;
		k_s4   <= 10'({2'b0, eg}) - 10'sd153;
		sg_s4  <= (sum == 32'd0) ? (prod_s3[31] & bias_s3[31]) : big[31];
		z_s4   <= (sum == 32'd0);
		nan_s4 <= a_nan || b_nan || (a_inf && b_inf && prod_s3[31] != bias_s3[31]);
		inf_s4 <= a_inf || b_inf;
	end

	always_ff @(posedge clk) begin
		a_s5   <= norm(sg_s4, z_s4, nan_s4, inf_s4, x_s4, k_s4);
		sum_s6 <= round_pack(a_s5);
	end

	always_ff @(posedge clk) begin
		case (fmt)
			FMT_FP32: res_s7 <= sum_s6;
			FMT_FP16: res_s7 <= {16'd0, single_to_half(sum_s6)};
			default:  res_s7 <= {16'd0, single_to_bf16(sum_s6)};
		endcase
	end

	assign res = res_s7;

endmodule

>>> sv/dq_merge.sv
// Merge stage: zeroes lanes beyond the count and registers the result word.
// Uses dq_pkg.
module dq_merge (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  vld,
	input  logic [2:0]            cnt,
	input  logic [3:0][31:0]      lane_res,
	output logic                  done,
	output dq_pkg::out_word_t     result
);
	import dq_pkg::*;

	logic             done_q;
	out_word_t        result_q;
	logic [3:0][31:0] m;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			m[i] = (3'(i) < cnt) ? lane_res[i] : 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld;
		end
	end

	always_ff @(posedge clk) begin
		result_q.out_lane0 <= m[0];
		result_q.out_lane1 <= m[1];
		result_q.out_lane2 <= m[2];
		result_q.out_lane3 <= m[3];
		result_q.out_count <= cnt;
	end

	assign done = done_q;
	assign result = result_q;

endmodule

>>> sv/rowwise_8bit_dequantizer.sv
// Top level of the row-wise 8-bit dequantizer: input register, scale/bias
// decode, parallel lanes and the merge stage. Uses dq_pkg, dq_lane, dq_merge.
//
// Takes one word of up to four bytes every clock; busy is never raised. Each
// word gives one result word on done, after the input register, scale/bias
// decode, seven lane stages and merge register. The lane pipeline sets the
// latency; the four lanes work side by side, so throughput is one word per
// cycle. Results cannot be held off.
module rowwise_8bit_dequantizer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  dq_pkg::in_word_t  item,
	output logic              done,
	output dq_pkg::out_word_t result,
	input  logic              cfg_we,
	input  logic              cfg_addr,
	input  logic [1:0]        cfg_wdata
);
	import dq_pkg::*;

	logic [1:0] fmt_q;
	logic       sbf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_FP32;
			sbf_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_OUT_FORMAT: fmt_q <= cfg_wdata;
				REG_SB_FLOAT:   sbf_q <= cfg_wdata[0];
				default:        ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic            vld_s1, vld_s2;
	in_word_t        in_s1;
	logic [31:0]     sc_s2, bi_s2;
	logic [3:0][7:0] q_s2;
	logic [2:0]      cnt_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		in_s1  <= item;
		sc_s2  <= sbf_q ? in_s1.scale_bits : half_to_single(in_s1.scale_bits[15:0]);
		bi_s2  <= sbf_q ? in_s1.bias_bits : half_to_single(in_s1.bias_bits[15:0]);
		q_s2   <= {in_s1.q_byte3, in_s1.q_byte2, in_s1.q_byte1, in_s1.q_byte0};
		cnt_s2 <= (in_s1.lanes_valid > CAP_CNT) ? CAP_CNT : in_s1.lanes_valid;
	end

	logic [3:0][31:0] lane_res;

	for (genvar i = 0; i < 4; i++) begin : g_lane
		if (i < CAP) begin : g_on
			dq_lane u_lane (
				.clk   (clk),
				.q     (q_s2[i]),
				.scale (sc_s2),
				.bias  (bi_s2),
				.fmt   (fmt_q),
				.res   (lane_res[i])
			);
		end else begin : g_off
			assign lane_res[i] = 32'd0;
		end
	end

	logic [LANE_DEPTH-1:0] vld_q;
	logic [2:0]            cnt_q [LANE_DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LANE_DEPTH-2:0], vld_s2};
		end
	end

	always_ff @(posedge clk) begin
		cnt_q[0] <= cnt_s2;
		for (int i = 1; i < LANE_DEPTH; i++) begin
			cnt_q[i] <= cnt_q[i-1];
		end
	end

	dq_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld      (vld_q[LANE_DEPTH-1]),
		.cnt      (cnt_q[LANE_DEPTH-1]),
		.lane_res (lane_res),
		.done     (done),
		.result   (result)
	);

endmodule

>>> tb/rowwise_8bit_dequantizer_tb.sv
// Testbench for rowwise_8bit_dequantizer: directed and random words, a scoreboard
// predicting each result in double arithmetic rounded to fp32/fp16/bf16.
// Depends on dq_pkg and the rowwise_8bit_dequantizer RTL.
`timescale 1ns / 1ps

module rowwise_8bit_dequantizer_tb;
	import dq_pkg::*;

	class dequant_scoreboard;
		out_word_t   exp_q[$];
		int          errors;
		logic [1:0]  fmt;
		logic        sb_float;

		function new();
			errors = 0;
			fmt = FMT_FP32;
			sb_float = 1'b1;
		endfunction

		// float bits with M mantissa bits, bias B, W exponent bits to real
		static function real bits_to_real(logic [31:0] bits, int M, int B, int W);
			int  e;
			int  m;
			real v;
			e = int'((bits >> M) & ((32'd1 << W) - 1));
			m = int'(bits & ((32'd1 << M) - 1));
			if (e == (1 << W) - 1) begin
				v = (m != 0) ? $bitstoreal(64'h7FF8000000000000) :
					$bitstoreal(64'h7FF0000000000000);
			end else if (e == 0) begin
				v = real'(m) * 2.0 ** (1 - B - M);
			end else begin
				v = (real'(m) + 2.0 ** M) * 2.0 ** (e - B - M);
			end
			return bits[M+W] ? -v : v;
		endfunction

		// real to float bits, nearest even, subnormals kept, canonical NaN
		static function logic [31:0] real_to_bits(real d, int M, int B, int W);
			logic [63:0] db;
			longint      sig;
			longint      r;
			longint      rem;
			longint      half;
			longint      pk;
			longint      infc;
			longint      sgn;
			int          ex;
			int          sh;
			db = $realtobits(d);
			infc = ((longint'(1) << W) - 1) << M;
			sgn = longint'(db[63]) << (M + W);
			if (db[62:52] == 11'h7FF) begin
				if (db[51:0] != 0)
					return 32'(infc | (longint'(1) << (M - 1)));
				return 32'(sgn | infc);
			end
			if (db[62:52] == 11'd0)
				return 32'(sgn);
			ex = int'(db[62:52]) - 1023;
			sig = longint'({1'b1, db[51:0]});
			sh = 52 - M;
			if (ex < 1 - B)
				sh = sh + (1 - B - ex);
			if (sh > 60)
				return 32'(sgn);
			r = sig >> sh;
			rem = sig & ((longint'(1) << sh) - 1);
			half = longint'(1) << (sh - 1);
			if (rem > half || (rem == half && r[0]))
				r = r + 1;
			pk = (ex >= 1 - B) ? (longint'(ex + B - 1) << M) + r : r;
			if (pk >= infc)
				pk = infc;
			return 32'(sgn | pk);
		endfunction

		function out_word_t dequantize(in_word_t w);
			out_word_t   o;
			logic [31:0] lanes[4];
			logic [7:0]  qb[4];
			logic [31:0] v;
			real         scale;
			real         bias;
			real         prod;
			int          cnt;
			qb = '{w.q_byte0, w.q_byte1, w.q_byte2, w.q_byte3};
			if (sb_float) begin
				scale = bits_to_real(w.scale_bits, 23, 127, 8);
				bias = bits_to_real(w.bias_bits, 23, 127, 8);
			end else begin
				scale = bits_to_real({16'd0, w.scale_bits[15:0]}, 10, 15, 5);
				bias = bits_to_real({16'd0, w.bias_bits[15:0]}, 10, 15, 5);
			end
			cnt = (w.lanes_valid > CAP) ? CAP : int'(w.lanes_valid);
			for (int i = 0; i < 4; i++) begin
				lanes[i] = '0;
				if (i < cnt) begin
					prod = bits_to_real(real_to_bits(real'(qb[i]) * scale, 23, 127, 8),
						23, 127, 8);
					v = real_to_bits(prod + bias, 23, 127, 8);
					case (fmt)
						FMT_FP32: lanes[i] = v;
						FMT_FP16: lanes[i] = real_to_bits(bits_to_real(v, 23, 127, 8),
							10, 15, 5);
						default: lanes[i] = real_to_bits(bits_to_real(v, 23, 127, 8),
							7, 127, 8);
					endcase
				end
			end
			o.out_lane0 = lanes[0];
			o.out_lane1 = lanes[1];
			o.out_lane2 = lanes[2];
			o.out_lane3 = lanes[3];
			o.out_count = 3'(cnt);
			return o;
		endfunction

		function void note_word(in_word_t w);
			exp_q.push_back(dequantize(w));
		endfunction

		function void check_result(out_word_t r);
			out_word_t e;
			if (exp_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result %h", r);
				return;
			end
			e = exp_q.pop_front();
			if (r.out_lane0 !== e.out_lane0 || r.out_lane1 !== e.out_lane1 ||
					r.out_lane2 !== e.out_lane2 || r.out_lane3 !== e.out_lane3 ||
					r.out_count !== e.out_count) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected %h actual %h", e, r);
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	in_word_t  item;
	logic      done;
	out_word_t result;
	logic      cfg_we;
	logic      cfg_addr;
	logic [1:0] cfg_wdata;

	dequant_scoreboard sb;
	int idle_pct;
	int stuck;

	rowwise_8bit_dequantizer DUT (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_word(item);
			if (done)
				sb.check_result(result);
			if ((start && !busy) || done) begin
				stuck <= 0;
			end else begin
				stuck <= stuck + 1;
			end
			if (stuck > 3000) begin
				$display("rowwise_8bit_dequantizer_tb NOT OK");
				$finish;
			end
		end
	end

	task automatic send_word(in_word_t w);
		while ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		item = w;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		start = 1'b0;
		while (sb.exp_q.size() != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic write_reg(logic addr, logic [1:0] data);
		cfg_we = 1'b1;
		cfg_addr = addr;
		cfg_wdata = data;
		@(negedge clk);
		cfg_we = 1'b0;
		if (addr == REG_OUT_FORMAT)
			sb.fmt = data;
		else
			sb.sb_float = data[0];
	endtask

	function automatic logic [31:0] rand_scalar(logic fp32);
		int k;
		k = $urandom_range(9);
		if (k < 3)
			return $urandom;
		if (fp32)
			return {1'($urandom_range(1)), 8'($urandom_range(100, 134)), 23'($urandom)};
		return {16'($urandom), 1'($urandom), 5'($urandom_range(3, 22)), 10'($urandom)};
	endfunction

	function automatic in_word_t rand_word(logic fp32);
		in_word_t w;
		w.q_byte0 = 8'($urandom);
		w.q_byte1 = 8'($urandom);
		w.q_byte2 = 8'($urandom);
		w.q_byte3 = 8'($urandom);
		w.lanes_valid = ($urandom_range(3) != 0) ? 3'd4 : 3'($urandom_range(7));
		w.scale_bits = rand_scalar(fp32);
		w.bias_bits = rand_scalar(fp32);
		return w;
	endfunction

	function automatic in_word_t mk(logic [7:0] a, logic [7:0] b, logic [2:0] n,
			logic [31:0] s, logic [31:0] bi);
		in_word_t w;
		w.q_byte0 = a;
		w.q_byte1 = b;
		w.q_byte2 = a ^ 8'hFF;
		w.q_byte3 = b ^ 8'hFF;
		w.lanes_valid = n;
		w.scale_bits = s;
		w.bias_bits = bi;
		return w;
	endfunction

	initial begin
		logic [1:0] fmts[7];
		logic       sbfs[7];
		sb = new();
		fmts = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2};
		sbfs = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_addr = REG_OUT_FORMAT;
		cfg_wdata = '0;
		idle_pct = 0;
		arst_n = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: byte extremes, lane counts, zero/inf/NaN/subnormal/huge scalars
		send_word(mk(8'd0, 8'd255, 3'd4, 32'h3F800000, 32'h00000000));
		send_word(mk(8'd255, 8'd0, 3'd0, 32'h3F800000, 32'h3F800000));
		send_word(mk(8'd1, 8'd2, 3'd1, 32'hBF800000, 32'h80000000));
		send_word(mk(8'd3, 8'd4, 3'd2, 32'h7F800000, 32'h00000000));
		send_word(mk(8'd0, 8'd5, 3'd3, 32'h7F800000, 32'h3F800000));
		send_word(mk(8'd6, 8'd7, 3'd5, 32'h7FC00001, 32'h00000000));
		send_word(mk(8'd8, 8'd9, 3'd7, 32'h00000001, 32'h80000001));
		send_word(mk(8'd255, 8'd254, 3'd6, 32'h7F7FFFFF, 32'h7F7FFFFF));
		send_word(mk(8'd255, 8'd128, 3'd4, 32'hFF7FFFFF, 32'hFF800000));
		send_word(mk(8'd0, 8'd0, 3'd4, 32'h80000000, 32'h80000000));
		send_word(mk(8'd17, 8'd200, 3'd4, 32'h33800001, 32'hB3800000));
		send_word(mk(8'd255, 8'd1, 3'd4, 32'hFFFFFFFF, 32'hFFFFFFFF));
		send_word(mk(8'd99, 8'd45, 3'd4, 32'h3C23D70A, 32'hC2C80000));

		for (int ph = 0; ph < 7; ph++) begin
			drain();
			write_reg(REG_OUT_FORMAT, fmts[ph]);
			write_reg(REG_SB_FLOAT, {1'b0, sbfs[ph]});
			idle_pct = (ph < 3) ? 19 : (ph < 5) ? 88 : 0;
			if (ph == 3) begin
				send_word(mk(8'd255, 8'd1, 3'd4, 32'hFFFF7BFF, 32'h12347BFF));
				send_word(mk(8'd2, 8'd3, 3'd4, 32'h00000001, 32'hFFFF8001));
				send_word(mk(8'd4, 8'd5, 3'd4, 32'h00007C00, 32'h0000FE01));
			end
			for (int i = 0; i < 275; i++)
				send_word(rand_word(sbfs[ph]));
		end
		drain();
		if (sb.errors == 0 && sb.exp_q.size() == 0) begin
			$display("rowwise_8bit_dequantizer_tb OK");
		end else begin
			$display("rowwise_8bit_dequantizer_tb NOT OK");
		end
		$finish;
	end

endmodule

>>> files.f
sv/dq_pkg.sv
sv/dq_lane.sv
sv/dq_merge.sv
sv/rowwise_8bit_dequantizer.sv
tb/rowwise_8bit_dequantizer_tb.sv
